### sv/sstg_pkg.sv
package sstg_pkg;

    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int QUEUE_DEPTH      = 2;
    localparam int SEG_BITS         = 16;

    localparam logic [10:0] NUM_SEGMENTS_RST       = 11'd1024;
    localparam logic [15:0] SEG_STRIPES_RST        = 16'd1024;
    localparam logic [19:0] BLOCKS_PER_SEGMENT_RST = 20'd32768;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_SEGMENTS       = 2'd0;
    localparam logic [1:0] CFG_SEG_STRIPES        = 2'd1;
    localparam logic [1:0] CFG_BLOCKS_PER_SEGMENT = 2'd2;

    localparam logic [3:0] OP_ADD_VALID    = 4'd0;
    localparam logic [3:0] OP_SUB_VALID    = 4'd1;
    localparam logic [3:0] OP_STRIPE       = 4'd2;
    localparam logic [3:0] OP_FREE         = 4'd3;
    localparam logic [3:0] OP_REPLAY       = 4'd4;
    localparam logic [3:0] OP_PICK_VICTIM  = 4'd5;
    localparam logic [3:0] OP_RESET_VICTIM = 4'd6;
    localparam logic [3:0] OP_FREE_INVAL   = 4'd7;
    localparam logic [3:0] OP_SET_STATE    = 4'd8;
    localparam logic [3:0] OP_QUERY        = 4'd9;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_OVERFLOW  = 3'd1;
    localparam logic [2:0] STATUS_UNDERFLOW = 3'd2;
    localparam logic [2:0] STATUS_NOT_FULL  = 3'd3;
    localparam logic [2:0] STATUS_RANGE     = 3'd4;

    localparam logic [1:0] ST_FREE   = 2'd0;
    localparam logic [1:0] ST_NVRAM  = 2'd1;
    localparam logic [1:0] ST_SSD    = 2'd2;
    localparam logic [1:0] ST_VICTIM = 2'd3;

    typedef struct packed {
        logic [3:0]          op;
        logic [SEG_BITS-1:0] seg;
        logic                oor;
        logic                aligned;
        logic [19:0]         count;
        logic [1:0]          new_state;
    } cmd_t;

    typedef struct packed {
        logic        al;
        logic [15:0] os;
        logic [19:0] vc;
        logic [1:0]  st;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  seg_state;
        logic [19:0] valid_count;
        logic        victim_found;
        logic [9:0]  victim_segment;
        logic        freed;
        logic [10:0] free_segments;
    } res_t;

endpackage

### sv/segment_state_table_gc_core.sv
// channel   direction  handshake             payload
// input     in         push / full           op, segment, lsid, count, new_state
// result    out        pop / empty           status, seg_state, valid_count, victim_found,
//                                            victim_segment, freed, free_segments
// config    in         cfg_write             cfg_index, cfg_data
//
// front end holds one item at a time; ops 2 and 4 first run a 32-step lsid divider unless seg_stripes is 0
// back end: a per-segment op has memory read, modify-write and result steps;
// out-of-range items and unused codes skip to the result; scan ops walk the
// segments in use, one memory entry per cycle, and a victim pick then marks the victim it found
// after reset a clearing pass over all MAX_SEGMENTS entries holds full high
// a two-entry queue sits between front and back, another before the result port
module segment_state_table_gc_core #(
    parameter int MAX_SEGMENTS = sstg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  op,
    input  logic [9:0]  segment,
    input  logic [31:0] lsid,
    input  logic [19:0] count,
    input  logic [1:0]  new_state,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [1:0]  seg_state,
    output logic [19:0] valid_count,
    output logic        victim_found,
    output logic [9:0]  victim_segment,
    output logic        freed,
    output logic [10:0] free_segments,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [10:0]    num_segments_reg;
    logic [15:0]    seg_stripes_reg;
    logic [19:0]    blocks_per_segment_reg;

    logic           clearing;
    logic           fr_valid;
    logic           fr_ready;
    sstg_pkg::cmd_t fr_cmd;
    logic           q_valid;
    logic           q_pop;
    sstg_pkg::cmd_t q_cmd;
    logic           bk_valid;
    logic           bk_ready;
    sstg_pkg::res_t bk_res;
    logic           out_valid;
    sstg_pkg::res_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_segments_reg       <= sstg_pkg::NUM_SEGMENTS_RST;
            seg_stripes_reg        <= sstg_pkg::SEG_STRIPES_RST;
            blocks_per_segment_reg <= sstg_pkg::BLOCKS_PER_SEGMENT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sstg_pkg::CFG_NUM_SEGMENTS:       num_segments_reg       <= cfg_data[10:0];
                sstg_pkg::CFG_SEG_STRIPES:        seg_stripes_reg        <= cfg_data[15:0];
                sstg_pkg::CFG_BLOCKS_PER_SEGMENT: blocks_per_segment_reg <= cfg_data;
                default:
                begin
                    num_segments_reg <= num_segments_reg;
                end
            endcase
        end
    end

    sstg_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .op                  (op),
        .segment             (segment),
        .lsid                (lsid),
        .count               (count),
        .new_state           (new_state),
        .clearing            (clearing),
        .num_segments        (num_segments_reg),
        .seg_stripes         (seg_stripes_reg),
        .cmd_valid           (fr_valid),
        .cmd_ready           (fr_ready),
        .cmd                 (fr_cmd)
    );

    sstg_fifo #(
        .WIDTH($bits(sstg_pkg::cmd_t)),
        .DEPTH(sstg_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_cmd),
        .out_valid (q_valid),
        .out_ready (q_pop),
        .out_data  (q_cmd)
    );

    sstg_back #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .num_segments        (num_segments_reg),
        .seg_stripes         (seg_stripes_reg),
        .blocks_per_segment  (blocks_per_segment_reg),
        .cmd_valid           (q_valid),
        .cmd_pop             (q_pop),
        .cmd                 (q_cmd),
        .res_valid           (bk_valid),
        .res_ready           (bk_ready),
        .res                 (bk_res),
        .clearing            (clearing)
    );

    sstg_fifo #(
        .WIDTH($bits(sstg_pkg::res_t)),
        .DEPTH(sstg_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bk_valid),
        .in_ready  (bk_ready),
        .in_data   (bk_res),
        .out_valid (out_valid),
        .out_ready (pop),
        .out_data  (out_res)
    );

    assign empty          = !out_valid;
    assign status         = out_res.status;
    assign seg_state      = out_res.seg_state;
    assign valid_count    = out_res.valid_count;
    assign victim_found   = out_res.victim_found;
    assign victim_segment = out_res.victim_segment;
    assign freed          = out_res.freed;
    assign free_segments  = out_res.free_segments;

endmodule

### sv/sstg_fifo.sv
module sstg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sstg_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### sv/sstg_front.sv
module sstg_front #(
    parameter int MAX_SEGMENTS = sstg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         op,
    input  logic [9:0]         segment,
    input  logic [31:0]        lsid,
    input  logic [19:0]        count,
    input  logic [1:0]         new_state,
    input  logic               clearing,
    input  logic [10:0]        num_segments,
    input  logic [15:0]        seg_stripes,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output sstg_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_HOLD = 3'b100
    } fstate_t;

    localparam logic [31:0] MAX_U = 32'(MAX_SEGMENTS);

    fstate_t        state_reg;
    fstate_t        state_next;
    sstg_pkg::cmd_t cmd_reg;
    sstg_pkg::cmd_t cmd_next;
    logic [31:0]    quo_reg;
    logic [31:0]    quo_next;
    logic [15:0]    rem_reg;
    logic [15:0]    rem_next;
    logic [4:0]     step_reg;
    logic [4:0]     step_next;

    logic [31:0]    n32;
    logic [16:0]    trial;
    logic           ge;
    logic [16:0]    diff;
    logic           accept;

    assign n32    = (32'(num_segments) < MAX_U) ? 32'(num_segments) : MAX_U;
    assign full   = (state_reg != F_IDLE) || clearing;
    assign accept = push && !full;

    // one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = (trial >= {1'b0, seg_stripes});
    assign diff  = trial - {1'b0, seg_stripes};

    assign cmd_valid = (state_reg == F_HOLD);
    assign cmd       = cmd_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    cmd_next.op        = op;
                    cmd_next.seg       = sstg_pkg::SEG_BITS'(segment);
                    cmd_next.oor       = (32'(segment) >= n32);
                    cmd_next.aligned   = 1'b0;
                    cmd_next.count     = count;
                    cmd_next.new_state = new_state;
                    if ((op == sstg_pkg::OP_STRIPE) || (op == sstg_pkg::OP_REPLAY))
                    begin
                        if (seg_stripes == '0)
                        begin
                            cmd_next.oor = 1'b1;
                            state_next   = F_HOLD;
                        end
                        else
                        begin
                            quo_next   = lsid;
                            rem_next   = '0;
                            step_next  = '0;
                            state_next = F_DIV;
                        end
                    end
                    else
                    begin
                        state_next = F_HOLD;
                    end
                end
            end
            F_DIV:
            begin
                quo_next  = {quo_reg[30:0], ge};
                rem_next  = ge ? diff[15:0] : trial[15:0];
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31)
                begin
                    cmd_next.seg     = quo_next[sstg_pkg::SEG_BITS-1:0];
                    cmd_next.oor     = (quo_next >= n32);
                    cmd_next.aligned = (rem_next == '0);
                    state_next       = F_HOLD;
                end
            end
            F_HOLD:
            begin
                if (cmd_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### sv/sstg_back.sv
module sstg_back #(
    parameter int MAX_SEGMENTS = sstg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [10:0]        num_segments,
    input  logic [15:0]        seg_stripes,
    input  logic [19:0]        blocks_per_segment,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  sstg_pkg::cmd_t     cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output sstg_pkg::res_t     res,
    output logic               clearing
);

    typedef enum logic [5:0] {
        B_CLEAR = 6'b000001,
        B_IDLE  = 6'b000010,
        B_EXEC  = 6'b000100,
        B_SCAN  = 6'b001000,
        B_PICK  = 6'b010000,
        B_OUT   = 6'b100000
    } bstate_t;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int TW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [31:0] MAX_U = 32'(MAX_SEGMENTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SEGMENTS - 1);

    sstg_pkg::entry_t mem [MAX_SEGMENTS];
    sstg_pkg::entry_t rd_data_reg;
    sstg_pkg::entry_t wr_data;
    logic [IW-1:0]    rd_addr;
    logic [IW-1:0]    wr_addr;
    logic             wr_en;

    bstate_t          state_reg;
    bstate_t          state_next;
    sstg_pkg::cmd_t   cur_reg;
    sstg_pkg::cmd_t   cur_next;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    idx_next;
    sstg_pkg::entry_t best_reg;
    sstg_pkg::entry_t best_next;
    logic [IW-1:0]    best_idx_reg;
    logic [IW-1:0]    best_idx_next;
    logic             found_reg;
    logic             found_next;
    logic [TW-1:0]    total_reg;
    logic [TW-1:0]    total_next;
    sstg_pkg::res_t   res_reg;
    sstg_pkg::res_t   res_next;

    logic [31:0]      n32;
    logic [31:0]      fs_diff;
    logic [31:0]      vseg32;
    logic             last;
    logic             is_scan;
    sstg_pkg::entry_t e;
    sstg_pkg::entry_t ne;
    logic [20:0]      sum;
    logic [15:0]      os_inc;

    assign n32      = (32'(num_segments) < MAX_U) ? 32'(num_segments) : MAX_U;
    assign fs_diff  = (n32 > 32'(total_reg)) ? (n32 - 32'(total_reg)) : '0;
    assign vseg32   = 32'(best_idx_reg);
    assign last     = (32'(idx_reg) == (n32 - 32'd1));
    assign is_scan  = (cmd.op == sstg_pkg::OP_PICK_VICTIM)
                   || (cmd.op == sstg_pkg::OP_RESET_VICTIM)
                   || (cmd.op == sstg_pkg::OP_FREE_INVAL);
    assign clearing = (state_reg == B_CLEAR);
    assign res_valid = (state_reg == B_OUT);

    always_comb
    begin
        res               = res_reg;
        res.free_segments = fs_diff[10:0];
    end

    always_comb
    begin
        if (state_reg == B_IDLE)
        begin
            rd_addr = is_scan ? '0 : cmd.seg[IW-1:0];
        end
        else
        begin
            rd_addr = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign e      = rd_data_reg;
    assign sum    = {1'b0, e.vc} + {1'b0, cur_reg.count};
    assign os_inc = (e.os != 16'hFFFF) ? e.os + 1'b1 : e.os;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        total_next    = total_reg;
        res_next      = res_reg;
        cmd_pop       = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = cur_reg.seg[IW-1:0];
        wr_data       = '0;
        ne            = e;
        unique case (state_reg)
            B_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cur_next   = cmd;
                    res_next   = '0;
                    state_next = B_OUT;
                    case (cmd.op) inside
                        sstg_pkg::OP_ADD_VALID, sstg_pkg::OP_SUB_VALID,
                        sstg_pkg::OP_STRIPE, sstg_pkg::OP_FREE, sstg_pkg::OP_REPLAY,
                        sstg_pkg::OP_SET_STATE, sstg_pkg::OP_QUERY:
                        begin
                            if (cmd.oor)
                            begin
                                res_next.status = sstg_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                state_next = B_EXEC;
                            end
                        end
                        sstg_pkg::OP_PICK_VICTIM, sstg_pkg::OP_RESET_VICTIM,
                        sstg_pkg::OP_FREE_INVAL:
                        begin
                            idx_next     = '0;
                            found_next   = 1'b0;
                            best_next    = '0;
                            best_next.vc = blocks_per_segment;
                            if (n32 != '0)
                            begin
                                state_next = B_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_EXEC:
            begin
                res_next = '0;
                case (cur_reg.op)
                    sstg_pkg::OP_ADD_VALID:
                    begin
                        if (sum > {1'b0, blocks_per_segment})
                        begin
                            ne.vc           = blocks_per_segment;
                            res_next.status = sstg_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            ne.vc = sum[19:0];
                        end
                    end
                    sstg_pkg::OP_SUB_VALID:
                    begin
                        if (cur_reg.count > e.vc)
                        begin
                            ne.vc           = '0;
                            res_next.status = sstg_pkg::STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            ne.vc = e.vc - cur_reg.count;
                        end
                    end
                    sstg_pkg::OP_STRIPE:
                    begin
                        ne.os = os_inc;
                        if (os_inc == seg_stripes)
                        begin
                            if (e.vc == '0)
                            begin
                                if (e.st != sstg_pkg::ST_FREE)
                                begin
                                    ne.os          = '0;
                                    ne.st          = sstg_pkg::ST_FREE;
                                    ne.al          = 1'b0;
                                    res_next.freed = 1'b1;
                                    if (e.al && (total_reg != '0))
                                    begin
                                        total_next = total_reg - 1'b1;
                                    end
                                end
                            end
                            else
                            begin
                                ne.st = sstg_pkg::ST_SSD;
                            end
                        end
                    end
                    sstg_pkg::OP_FREE:
                    begin
                        if ((e.st == sstg_pkg::ST_SSD) || (e.st == sstg_pkg::ST_VICTIM))
                        begin
                            if (e.os != seg_stripes)
                            begin
                                res_next.status = sstg_pkg::STATUS_NOT_FULL;
                            end
                            ne.os          = '0;
                            ne.st          = sstg_pkg::ST_FREE;
                            ne.al          = 1'b0;
                            res_next.freed = 1'b1;
                            if (e.al && (total_reg != '0))
                            begin
                                total_next = total_reg - 1'b1;
                            end
                        end
                    end
                    sstg_pkg::OP_REPLAY:
                    begin
                        if (cur_reg.aligned && (e.st == sstg_pkg::ST_FREE))
                        begin
                            ne.st = sstg_pkg::ST_NVRAM;
                            if (!e.al)
                            begin
                                ne.al      = 1'b1;
                                total_next = total_reg + 1'b1;
                            end
                        end
                    end
                    sstg_pkg::OP_SET_STATE:
                    begin
                        ne.st = cur_reg.new_state;
                    end
                    default:
                    begin
                        ne = e;
                    end
                endcase
                wr_en                = 1'b1;
                wr_data              = ne;
                res_next.seg_state   = ne.st;
                res_next.valid_count = ne.vc;
                state_next           = B_OUT;
            end
            B_SCAN:
            begin
                wr_addr  = idx_reg;
                wr_data  = e;
                idx_next = idx_reg + 1'b1;
                case (cur_reg.op)
                    sstg_pkg::OP_PICK_VICTIM:
                    begin
                        if ((e.st == sstg_pkg::ST_SSD) && (e.vc != '0)
                            && (e.vc < best_reg.vc))
                        begin
                            best_next     = e;
                            best_idx_next = idx_reg;
                            found_next    = 1'b1;
                        end
                    end
                    sstg_pkg::OP_RESET_VICTIM:
                    begin
                        if (e.st == sstg_pkg::ST_VICTIM)
                        begin
                            wr_en      = 1'b1;
                            wr_data.st = sstg_pkg::ST_SSD;
                        end
                    end
                    default:
                    begin
                        if ((e.st == sstg_pkg::ST_SSD) && (e.vc == '0))
                        begin
                            wr_en      = 1'b1;
                            wr_data.st = sstg_pkg::ST_FREE;
                        end
                    end
                endcase
                if (last)
                begin
                    state_next = (cur_reg.op == sstg_pkg::OP_PICK_VICTIM) ? B_PICK : B_OUT;
                end
            end
            B_PICK:
            begin
                res_next = '0;
                if (found_reg)
                begin
                    wr_en                   = 1'b1;
                    wr_addr                 = best_idx_reg;
                    wr_data                 = best_reg;
                    wr_data.st              = sstg_pkg::ST_VICTIM;
                    res_next.seg_state      = sstg_pkg::ST_VICTIM;
                    res_next.valid_count    = best_reg.vc;
                    res_next.victim_found   = 1'b1;
                    res_next.victim_segment = vseg32[9:0];
                end
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (res_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            total_reg <= total_next;
        end
    end

endmodule

### tb/sv/segment_state_table_gc_core_checker.sv
`timescale 1ns / 1ps

module segment_state_table_gc_core_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [3:0]  op,
    input  logic [9:0]  segment,
    input  logic [31:0] lsid,
    input  logic [19:0] count,
    input  logic [1:0]  new_state,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  status,
    input  logic [1:0]  seg_state,
    input  logic [19:0] valid_count,
    input  logic        victim_found,
    input  logic [9:0]  victim_segment,
    input  logic        freed,
    input  logic [10:0] free_segments,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int          errors,
    output int          pending
);

    logic [1:0]  state_tab [1024];
    logic [19:0] valid_tab [1024];
    logic [15:0] stripe_tab [1024];
    logic        alloc_tab [1024];
    int          alloc_total;
    logic [10:0] num_segs;
    logic [15:0] stripes;
    logic [19:0] blocks;

    sstg_pkg::res_t expected_results [$];

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        errors++;
    endtask

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin : table_model
        int             n;
        int             s;
        int             i;
        logic           ok;
        logic           addressed;
        logic [20:0]    sum;
        logic [19:0]    minv;
        logic [31:0]    q;
        sstg_pkg::res_t r;
        sstg_pkg::res_t got;
        if (!rst_n)
        begin
            for (i = 0; i < 1024; i++)
            begin
                state_tab[i] = sstg_pkg::ST_FREE;
                valid_tab[i] = '0;
                stripe_tab[i] = '0;
                alloc_tab[i] = 1'b0;
            end
            alloc_total = 0;
            num_segs = sstg_pkg::NUM_SEGMENTS_RST;
            stripes = sstg_pkg::SEG_STRIPES_RST;
            blocks = sstg_pkg::BLOCKS_PER_SEGMENT_RST;
            expected_results.delete();
            errors = 0;
        end
        else
        begin
            // result side first: a result cannot be the item pushed at the same edge
            if (pop && !empty)
            begin
                got = '{status, seg_state, valid_count, victim_found, victim_segment,
                        freed, free_segments};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no item outstanding", $realtime);
                    errors++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    if (got.status !== r.status)
                        report_mismatch("status", got.status, r.status);
                    if (got.seg_state !== r.seg_state)
                        report_mismatch("seg_state", got.seg_state, r.seg_state);
                    if (got.valid_count !== r.valid_count)
                        report_mismatch("valid_count", got.valid_count, r.valid_count);
                    if (got.victim_found !== r.victim_found)
                        report_mismatch("victim_found", got.victim_found, r.victim_found);
                    if (got.victim_segment !== r.victim_segment)
                        report_mismatch("victim_segment", got.victim_segment,
                                        r.victim_segment);
                    if (got.freed !== r.freed)
                        report_mismatch("freed", got.freed, r.freed);
                    if (got.free_segments !== r.free_segments)
                        report_mismatch("free_segments", got.free_segments,
                                        r.free_segments);
                end
            end

            if (cfg_write)
            begin
                if (cfg_index == sstg_pkg::CFG_NUM_SEGMENTS)
                    num_segs = cfg_data[10:0];
                else if (cfg_index == sstg_pkg::CFG_SEG_STRIPES)
                    stripes = cfg_data[15:0];
                else if (cfg_index == sstg_pkg::CFG_BLOCKS_PER_SEGMENT)
                    blocks = cfg_data;
            end

            if (push && !full)
            begin
                n = (num_segs < 1024) ? num_segs : 1024;
                r = '0;
                addressed = 1'b0;
                s = 0;
                if (op <= sstg_pkg::OP_REPLAY || op == sstg_pkg::OP_SET_STATE
                    || op == sstg_pkg::OP_QUERY)
                begin
                    if (op == sstg_pkg::OP_STRIPE || op == sstg_pkg::OP_REPLAY)
                    begin
                        if (stripes == 0)
                            ok = 1'b0;
                        else
                        begin
                            q = lsid / stripes;
                            ok = q < n;
                            s = ok ? int'(q) : 0;
                        end
                    end
                    else
                    begin
                        s = segment;
                        ok = s < n;
                    end
                    if (!ok)
                    begin
                        r.status = sstg_pkg::STATUS_RANGE;
                        s = 0;
                    end
                    else
                    begin
                        addressed = 1'b1;
                        case (op)
                            sstg_pkg::OP_ADD_VALID:
                            begin
                                sum = valid_tab[s] + count;
                                if (sum > blocks)
                                begin
                                    sum = blocks;
                                    r.status = sstg_pkg::STATUS_OVERFLOW;
                                end
                                valid_tab[s] = sum[19:0];
                            end
                            sstg_pkg::OP_SUB_VALID:
                            begin
                                if (count > valid_tab[s])
                                begin
                                    valid_tab[s] = '0;
                                    r.status = sstg_pkg::STATUS_UNDERFLOW;
                                end
                                else
                                    valid_tab[s] = valid_tab[s] - count;
                            end
                            sstg_pkg::OP_STRIPE:
                            begin
                                if (stripe_tab[s] != 16'hFFFF)
                                    stripe_tab[s]++;
                                if (stripe_tab[s] == stripes)
                                begin
                                    if (valid_tab[s] == 0)
                                    begin
                                        if (state_tab[s] != sstg_pkg::ST_FREE)
                                        begin
                                            stripe_tab[s] = '0;
                                            state_tab[s] = sstg_pkg::ST_FREE;
                                            if (alloc_tab[s])
                                            begin
                                                alloc_tab[s] = 1'b0;
                                                if (alloc_total > 0) alloc_total--;
                                            end
                                            r.freed = 1'b1;
                                        end
                                    end
                                    else
                                        state_tab[s] = sstg_pkg::ST_SSD;
                                end
                            end
                            sstg_pkg::OP_FREE:
                            begin
                                if (state_tab[s] == sstg_pkg::ST_SSD
                                    || state_tab[s] == sstg_pkg::ST_VICTIM)
                                begin
                                    if (stripe_tab[s] != stripes)
                                        r.status = sstg_pkg::STATUS_NOT_FULL;
                                    stripe_tab[s] = '0;
                                    state_tab[s] = sstg_pkg::ST_FREE;
                                    if (alloc_tab[s])
                                    begin
                                        alloc_tab[s] = 1'b0;
                                        if (alloc_total > 0) alloc_total--;
                                    end
                                    r.freed = 1'b1;
                                end
                            end
                            sstg_pkg::OP_REPLAY:
                            begin
                                if (lsid % stripes == 0 && state_tab[s] == sstg_pkg::ST_FREE)
                                begin
                                    state_tab[s] = sstg_pkg::ST_NVRAM;
                                    if (!alloc_tab[s])
                                    begin
                                        alloc_tab[s] = 1'b1;
                                        alloc_total++;
                                    end
                                end
                            end
                            sstg_pkg::OP_SET_STATE:
                                state_tab[s] = new_state;
                            default: ;
                        endcase
                    end
                end
                else if (op == sstg_pkg::OP_PICK_VICTIM)
                begin
                    minv = blocks;
                    for (i = 0; i < n; i++)
                        if (state_tab[i] == sstg_pkg::ST_SSD && valid_tab[i] != 0
                            && valid_tab[i] < minv)
                        begin
                            minv = valid_tab[i];
                            r.victim_segment = i[9:0];
                            r.victim_found = 1'b1;
                        end
                    if (r.victim_found)
                    begin
                        state_tab[r.victim_segment] = sstg_pkg::ST_VICTIM;
                        s = r.victim_segment;
                        addressed = 1'b1;
                    end
                end
                else if (op == sstg_pkg::OP_RESET_VICTIM)
                begin
                    for (i = 0; i < n; i++)
                        if (state_tab[i] == sstg_pkg::ST_VICTIM)
                            state_tab[i] = sstg_pkg::ST_SSD;
                end
                else if (op == sstg_pkg::OP_FREE_INVAL)
                begin
                    for (i = 0; i < n; i++)
                        if (state_tab[i] == sstg_pkg::ST_SSD && valid_tab[i] == 0)
                            state_tab[i] = sstg_pkg::ST_FREE;
                end
                if (addressed)
                begin
                    r.seg_state = state_tab[s];
                    r.valid_count = valid_tab[s];
                end
                r.free_segments = (n > alloc_total) ? 11'(n - alloc_total) : 11'd0;
                expected_results.push_back(r);
            end
        end
    end

endmodule

### tb/sv/segment_state_table_gc_core_test.sv
`timescale 1ns / 1ps

module segment_state_table_gc_core_test;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [3:0]  op;
    logic [9:0]  segment;
    logic [31:0] lsid;
    logic [19:0] count;
    logic [1:0]  new_state;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [1:0]  seg_state;
    logic [19:0] valid_count;
    logic        victim_found;
    logic [9:0]  victim_segment;
    logic        freed;
    logic [10:0] free_segments;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;
    int          errors;
    int          pending;

    int          items_sent;
    int          num_cur;
    int          stripes_cur;
    int          blocks_cur;
    bit          busy_phase;
    int          pop_rate;

    segment_state_table_gc_core uut (.*);

    segment_state_table_gc_core_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial
    begin : result_drain
        int gap_left;
        bit held;
        gap_left = 0;
        held = 1'b0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= 400)
            begin
                held = 1'b1;
                gap_left = 600;
            end
            if (gap_left > 0)
            begin
                pop <= 1'b0;
                gap_left--;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) < pop_rate);
                if ($urandom_range(0, 99) == 0)
                    gap_left = $urandom_range(15, 60);
            end
        end
    end

    task automatic send_item(input logic [3:0] o, input logic [9:0] sg, input logic [31:0] ls,
                             input logic [19:0] cnt, input logic [1:0] ns);
        int gap;
        op <= o;
        segment <= sg;
        lsid <= ls;
        count <= cnt;
        new_state <= ns;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
        if (busy_phase)
            gap = 0;
        else if ($urandom_range(0, 9) < 6)
            gap = 0;
        else if ($urandom_range(0, 9) < 8)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 40);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic configure(input int n, input int sps, input int bps);
        push <= 1'b0;
        // let the checker book the last accepted item first
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sstg_pkg::CFG_NUM_SEGMENTS;
        cfg_data <= 20'(n);
        @(posedge clk);
        cfg_index <= sstg_pkg::CFG_SEG_STRIPES;
        cfg_data <= 20'(sps);
        @(posedge clk);
        cfg_index <= sstg_pkg::CFG_BLOCKS_PER_SEGMENT;
        cfg_data <= 20'(bps);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        num_cur = (n < 1024) ? n : 1024;
        stripes_cur = sps;
        blocks_cur = bps;
    endtask

    task automatic random_items(input int total, input int scan_weight);
        int          k;
        int          pick;
        logic [3:0]  o;
        logic [9:0]  sg;
        logic [31:0] ls;
        logic [19:0] cnt;
        for (k = 0; k < total; k++)
        begin
            if (k % 60 == 0)
            begin
                busy_phase = ($urandom_range(0, 3) == 0);
                pop_rate = $urandom_range(0, 2) == 0 ? 100 : $urandom_range(30, 90);
            end
            pick = $urandom_range(0, 99);
            if (pick < scan_weight)
                o = sstg_pkg::OP_PICK_VICTIM + 4'($urandom_range(0, 2));
            else if (pick < scan_weight + 3)
                o = 4'($urandom_range(10, 15));
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1:    o = sstg_pkg::OP_ADD_VALID;
                    2:       o = sstg_pkg::OP_SUB_VALID;
                    3, 4, 5: o = sstg_pkg::OP_STRIPE;
                    6:       o = sstg_pkg::OP_FREE;
                    7:       o = sstg_pkg::OP_REPLAY;
                    8:       o = sstg_pkg::OP_SET_STATE;
                    default: o = sstg_pkg::OP_QUERY;
                endcase
            end
            // mostly segments in use, a few past the end
            if ($urandom_range(0, 15) == 0)
                sg = 10'($urandom);
            else
                sg = 10'($urandom_range(0, num_cur - 1 + (num_cur + 7) / 8));
            if ($urandom_range(0, 19) == 0 || stripes_cur == 0)
                ls = $urandom;
            else if (o == sstg_pkg::OP_REPLAY && $urandom_range(0, 3) != 0)
                ls = sg * stripes_cur;
            else
                ls = sg * stripes_cur + $urandom_range(0, stripes_cur - 1);
            if ($urandom_range(0, 9) == 0)
                cnt = 20'($urandom);
            else
                cnt = 20'($urandom_range(0, blocks_cur / 3 + 1));
            send_item(o, sg, ls, cnt, 2'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        op = '0;
        segment = '0;
        lsid = '0;
        count = '0;
        new_state = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        busy_phase = 1'b0;
        pop_rate = 80;
        num_cur = 1024;
        stripes_cur = 1024;
        blocks_cur = 32768;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(16, 2, 100);
        // directed: allocation, counts, stripes, victims, frees, ranges
        send_item(sstg_pkg::OP_REPLAY, 0, 32'd0, 0, 0);
        send_item(sstg_pkg::OP_REPLAY, 0, 32'd3, 0, 0);
        send_item(sstg_pkg::OP_REPLAY, 0, 32'd2, 0, 0);
        send_item(sstg_pkg::OP_ADD_VALID, 0, 0, 20'd50, 0);
        send_item(sstg_pkg::OP_ADD_VALID, 0, 0, 20'd100, 0);
        send_item(sstg_pkg::OP_SUB_VALID, 0, 0, 20'd30, 0);
        send_item(sstg_pkg::OP_SUB_VALID, 0, 0, 20'd1000, 0);
        send_item(sstg_pkg::OP_ADD_VALID, 0, 0, 20'd20, 0);
        send_item(sstg_pkg::OP_STRIPE, 0, 32'd0, 0, 0);
        send_item(sstg_pkg::OP_STRIPE, 0, 32'd1, 0, 0);
        send_item(sstg_pkg::OP_ADD_VALID, 1, 0, 20'd5, 0);
        send_item(sstg_pkg::OP_SET_STATE, 1, 0, 0, sstg_pkg::ST_SSD);
        send_item(sstg_pkg::OP_PICK_VICTIM, 0, 0, 0, 0);
        send_item(sstg_pkg::OP_RESET_VICTIM, 0, 0, 0, 0);
        send_item(sstg_pkg::OP_PICK_VICTIM, 0, 0, 0, 0);
        send_item(sstg_pkg::OP_FREE, 1, 0, 0, 0);
        send_item(sstg_pkg::OP_FREE, 3, 0, 0, 0);
        send_item(sstg_pkg::OP_QUERY, 10'h3FF, 0, 0, 0);
        send_item(sstg_pkg::OP_STRIPE, 0, 32'hFFFF_FFFE, 0, 0);
        send_item(sstg_pkg::OP_SET_STATE, 5, 0, 0, sstg_pkg::ST_SSD);
        send_item(sstg_pkg::OP_FREE_INVAL, 0, 0, 0, 0);
        send_item(sstg_pkg::OP_ADD_VALID, 2, 0, 20'hFFFFF, sstg_pkg::ST_VICTIM);
        send_item(4'd10, 10'h2AA, 32'h5555_5555, 20'h55555, sstg_pkg::ST_NVRAM);
        send_item(4'd15, 0, 0, 0, 0);
        send_item(sstg_pkg::OP_QUERY, 0, 0, 0, 0);
        random_items(250, 15);

        configure(1, 1, 1);
        random_items(150, 15);
        configure(2047, 65535, 20'hFFFFF);
        random_items(200, 2);
        configure(64, 0, 500);
        random_items(200, 10);
        configure(8, 3, 20);
        random_items(300, 15);
        configure(200, 4, 20'hFFFFF);
        random_items(325, 8);
        push <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
sv/sstg_pkg.sv
sv/sstg_fifo.sv
sv/sstg_front.sv
sv/sstg_back.sv
sv/segment_state_table_gc_core.sv
tb/sv/segment_state_table_gc_core_checker.sv
tb/sv/segment_state_table_gc_core_test.sv
